### hw/rtl/ohlc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ohlc_pkg
// shared types and constants for the column aggregator
// ----------------------------------------------------------------------------
package ohlc_pkg;

    localparam int COLUMN_BITS = 14;
    localparam int TIME_BITS   = 63;
    localparam int CNT_BITS    = $clog2(COLUMN_BITS + 1);

    localparam logic [1:0] REG_RANGE_START = 2'd0;
    localparam logic [1:0] REG_RANGE_END   = 2'd1;
    localparam logic [1:0] REG_PLOT_WIDTH  = 2'd2;

    typedef struct packed {
        logic [TIME_BITS-1:0] bar_time;
        logic signed [63:0]   open_price;
        logic signed [63:0]   high_price;
        logic signed [63:0]   low_price;
        logic signed [63:0]   close_price;
        logic [63:0]          volume;
        logic [63:0]          trades;
        logic [7:0]           source_tag;
        logic [7:0]           bar_state;
        logic [31:0]          revision;
        logic                 last_in;
    } t_bar;

    // classified bar on its way to the back end
    typedef struct packed {
        t_bar                   bar;
        logic [COLUMN_BITS-1:0] column;
    } t_cls;

    typedef struct packed {
        logic [TIME_BITS-1:0] out_time;
        logic signed [63:0]   out_open;
        logic signed [63:0]   out_high;
        logic signed [63:0]   out_low;
        logic signed [63:0]   out_close;
        logic [63:0]          out_volume;
        logic [63:0]          out_trades;
        logic [7:0]           out_source;
        logic [7:0]           out_state;
        logic [31:0]          out_revision;
        logic                 vwap_kept;
        logic                 last_out;
    } t_res;

    typedef enum logic [1:0] {
        t_FE_IDLE,
        t_FE_DIV,
        t_FE_PUSH
    } t_fe_state;

endpackage
`default_nettype wire

### hw/rtl/ohlc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ohlc_front
// takes bars, drops them when the view is invalid, and finds the column of
// an in-view bar with a bit-serial scaled divider, one width bit per cycle
// ----------------------------------------------------------------------------
module ohlc_front
    import ohlc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire t_bar                   i_bar,
    input  wire logic [TIME_BITS-1:0]   i_range_start,
    input  wire logic [TIME_BITS-1:0]   i_range_end,
    input  wire logic [COLUMN_BITS-1:0] i_plot_width,
    output logic                        o_push,
    output t_cls                        o_cls,
    input  wire logic                   i_full
);

    t_fe_state r_state, n_state;
    t_bar r_bar;
    logic [TIME_BITS-1:0]   r_d, r_r;
    logic [TIME_BITS:0]     r_rem;
    logic [COLUMN_BITS-1:0] r_q;
    logic [CNT_BITS-1:0]    r_cnt;
    logic                   w_ok, w_acc;
    logic [TIME_BITS:0]     w_s1, w_s2, w_r1, w_s3, w_r2;
    logic                   w_q1, w_q2;
    logic [CNT_BITS-1:0]    w_bit;

    assign w_ok  = (i_plot_width != '0) && (i_range_end > i_range_start);
    assign o_stall = (r_state != t_FE_IDLE);
    assign w_acc = i_valid && !o_stall;
    assign w_bit = r_cnt - CNT_BITS'(1);

    // one step of the scaled division: double, then add d where width bit set
    always_comb begin
        w_s1 = {r_rem[TIME_BITS-1:0], 1'b0};
        w_q1 = (w_s1 >= {1'b0, r_r});
        w_r1 = w_q1 ? w_s1 - {1'b0, r_r} : w_s1;
        w_s3 = w_r1 + {1'b0, r_d};
        w_q2 = i_plot_width[w_bit[$clog2(COLUMN_BITS)-1:0]] && (w_s3 >= {1'b0, r_r});
        w_s2 = i_plot_width[w_bit[$clog2(COLUMN_BITS)-1:0]] ? w_s3 : w_r1;
        w_r2 = w_q2 ? w_s2 - {1'b0, r_r} : w_s2;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            t_FE_IDLE: begin
                if (w_acc && w_ok) begin
                    if (i_bar.bar_time <= i_range_start || i_bar.bar_time >= i_range_end)
                        n_state = t_FE_PUSH;
                    else
                        n_state = t_FE_DIV;
                end
            end
            t_FE_DIV:  if (r_cnt == CNT_BITS'(1)) n_state = t_FE_PUSH;
            t_FE_PUSH: if (!i_full) n_state = t_FE_IDLE;
            default:   n_state = t_FE_IDLE;
        endcase
    end

    always_comb begin
        o_push = (r_state == t_FE_PUSH) && !i_full;
        o_cls.bar = r_bar;
        o_cls.column = r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_FE_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (r_state == t_FE_IDLE && w_acc) begin
            r_bar <= i_bar;
            r_d   <= i_bar.bar_time - i_range_start;
            r_r   <= i_range_end - i_range_start;
            r_rem <= '0;
            r_cnt <= CNT_BITS'(COLUMN_BITS);
            if (i_bar.bar_time <= i_range_start) r_q <= '0;
            else if (i_bar.bar_time >= i_range_end) r_q <= i_plot_width;
            else r_q <= '0;
        end else if (r_state == t_FE_DIV) begin
            r_rem <= w_r2;
            r_q   <= {r_q[COLUMN_BITS-2:0], 1'b0} + COLUMN_BITS'(w_q1) + COLUMN_BITS'(w_q2);
            r_cnt <= w_bit;
        end
    end

    property p_push_full;
        @(posedge i_clk) disable iff (!i_rst_n) o_push |-> !i_full;
    endproperty
    a_push_full: assert property (p_push_full) else $error("push into full queue");

    property p_div_ends;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == t_FE_DIV && r_cnt == CNT_BITS'(1)) |=> (r_state == t_FE_PUSH);
    endproperty
    a_div_ends: assert property (p_div_ends) else $error("divider did not finish");

    property p_busy;
        @(posedge i_clk) disable iff (!i_rst_n) (r_state == t_FE_DIV) |-> o_stall;
    endproperty
    a_busy: assert property (p_busy) else $error("accepted while dividing");

endmodule
`default_nettype wire

### hw/rtl/ohlc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ohlc_queue
// two-entry queue between the front and back ends
// ----------------------------------------------------------------------------
module ohlc_queue
    import ohlc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cls i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_cls      o_data
);

    t_cls r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_data;
    end

    property p_no_under;
        @(posedge i_clk) disable iff (!i_rst_n) i_pop |-> !o_empty;
    endproperty
    a_no_under: assert property (p_no_under) else $error("queue underflow");

    property p_cnt;
        @(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3;
    endproperty
    a_cnt: assert property (p_cnt) else $error("queue count out of range");

    property p_ptr;
        @(posedge i_clk) disable iff (!i_rst_n) (r_cnt != 2'd1) |-> (r_wp == r_rp);
    endproperty
    a_ptr: assert property (p_ptr) else $error("queue pointers disagree");

endmodule
`default_nettype wire

### hw/rtl/ohlc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ohlc_back
// merges classified bars into the pending column group and emits groups
// through a two-slot output buffer
// ----------------------------------------------------------------------------
module ohlc_back
    import ohlc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_empty,
    input  wire t_cls i_cls,
    output logic      o_pop,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_res      o_res
);

    logic r_open, r_single;
    logic [COLUMN_BITS-1:0] r_col;
    t_res r_grp;
    t_res r_ob [2];
    logic [1:0] r_ocnt;
    logic w_merge, w_take;
    t_res w_disp, w_new, w_flush;
    logic [1:0] w_nres;
    logic [64:0] w_vs, w_ts;
    t_bar b;

    assign b = i_cls.bar;
    assign w_merge = r_open && (i_cls.column == r_col);
    assign w_nres = 2'(r_open && !w_merge) + 2'(b.last_in);
    // only take a bar when both its results fit in the output buffer
    assign o_pop = !i_empty && (r_ocnt == 2'd0);
    assign w_take = o_pop;
    assign o_valid = (r_ocnt != 2'd0);
    assign o_res = r_ob[0];

    always_comb begin
        w_vs = {1'b0, r_grp.out_volume} + {1'b0, b.volume};
        w_ts = {1'b0, r_grp.out_trades} + {1'b0, b.trades};
        w_disp = r_grp;
        w_disp.vwap_kept = r_single;
        w_disp.last_out = 1'b0;
        w_new = r_grp;
        if (w_merge) begin
            if (b.high_price > r_grp.out_high) w_new.out_high = b.high_price;
            if (b.low_price < r_grp.out_low) w_new.out_low = b.low_price;
            w_new.out_close = b.close_price;
            w_new.out_volume = w_vs[64] ? '1 : w_vs[63:0];
            w_new.out_trades = w_ts[64] ? '1 : w_ts[63:0];
            w_new.out_source = b.source_tag;
            w_new.out_state = b.bar_state;
            if (b.revision > r_grp.out_revision) w_new.out_revision = b.revision;
            w_new.vwap_kept = 1'b0;
        end else begin
            w_new.out_time = b.bar_time;
            w_new.out_open = b.open_price;
            w_new.out_high = b.high_price;
            w_new.out_low = b.low_price;
            w_new.out_close = b.close_price;
            w_new.out_volume = b.volume;
            w_new.out_trades = b.trades;
            w_new.out_source = b.source_tag;
            w_new.out_state = b.bar_state;
            w_new.out_revision = b.revision;
            w_new.vwap_kept = 1'b1;
        end
        w_new.last_out = 1'b0;
        w_flush = w_new;
        w_flush.last_out = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_single <= 1'b0;
            r_ocnt <= '0;
        end else if (w_take) begin
            r_open <= !b.last_in;
            r_single <= w_new.vwap_kept;
            r_ocnt <= w_nres;
        end else if (o_valid && !i_stall) begin
            r_ocnt <= r_ocnt - 2'd1;
        end
        if (w_take) begin
            r_col <= i_cls.column;
            r_grp <= w_new;
            if (r_open && !w_merge) begin
                r_ob[0] <= w_disp;
                r_ob[1] <= w_flush;
            end else begin
                r_ob[0] <= w_flush;
            end
        end else if (o_valid && !i_stall) begin
            r_ob[0] <= r_ob[1];
        end
    end

    property p_take_idle;
        @(posedge i_clk) disable iff (!i_rst_n) o_pop |-> !o_valid;
    endproperty
    a_take_idle: assert property (p_take_idle) else $error("bar taken while output busy");

    property p_last_closes;
        @(posedge i_clk) disable iff (!i_rst_n) (o_pop && b.last_in) |=> !r_open;
    endproperty
    a_last_closes: assert property (p_last_closes) else $error("group left open after last");

    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            (o_valid && i_stall) |=> (o_valid && $stable(o_res));
    endproperty
    a_hold: assert property (p_hold) else $error("stalled result changed");

endmodule
`default_nettype wire

### hw/rtl/ohlc_column_aggregator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ohlc_column_aggregator
// decimates time-ordered ohlc bars into per-column groups for plotting
// ----------------------------------------------------------------------------
// usage: bars arrive on the i_ valid/stall channel, groups leave on the o_
// valid/stall channel. registers are written through i_cfg_we / i_cfg_index /
// i_cfg_data while no bar is in flight.
// the front end classifies a bar directly when its time is outside the view,
// or with the bit-serial scaled divider, one width bit per cycle, when the
// column needs it; it takes no new bar until it has pushed the last one.
// a two-entry queue decouples it from the merge back end, which takes a bar
// once its output buffer is empty and then presents up to two
// results, a displaced group followed by the flushed last group.
// when the view is invalid a bar is dropped with no result.
// reset closes the group, empties the queue and clears the registers to zero.
// a stalled receiver holds the result steady and backs up into the queue and
// then the input stall.
// ----------------------------------------------------------------------------
module ohlc_column_aggregator
    import ohlc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [TIME_BITS-1:0] i_bar_time,
    input  wire logic signed [63:0]   i_open_price,
    input  wire logic signed [63:0]   i_high_price,
    input  wire logic signed [63:0]   i_low_price,
    input  wire logic signed [63:0]   i_close_price,
    input  wire logic [63:0]          i_volume,
    input  wire logic [63:0]          i_trades,
    input  wire logic [7:0]           i_source_tag,
    input  wire logic [7:0]           i_bar_state,
    input  wire logic [31:0]          i_revision,
    input  wire logic                 i_last_in,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [TIME_BITS-1:0] i_cfg_data,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [TIME_BITS-1:0]      o_out_time,
    output logic signed [63:0]        o_out_open,
    output logic signed [63:0]        o_out_high,
    output logic signed [63:0]        o_out_low,
    output logic signed [63:0]        o_out_close,
    output logic [63:0]               o_out_volume,
    output logic [63:0]               o_out_trades,
    output logic [7:0]                o_out_source,
    output logic [7:0]                o_out_state,
    output logic [31:0]               o_out_revision,
    output logic                      o_vwap_kept,
    output logic                      o_last_out
);

    logic [TIME_BITS-1:0]   r_range_start, r_range_end;
    logic [COLUMN_BITS-1:0] r_plot_width;
    t_bar w_bar;
    t_cls w_qin, w_qout;
    logic w_push, w_full, w_pop, w_empty;
    t_res w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_start <= '0;
            r_range_end <= '0;
            r_plot_width <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_RANGE_START: r_range_start <= i_cfg_data;
                REG_RANGE_END:   r_range_end <= i_cfg_data;
                REG_PLOT_WIDTH:  r_plot_width <= i_cfg_data[COLUMN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_bar.bar_time = i_bar_time;
        w_bar.open_price = i_open_price;
        w_bar.high_price = i_high_price;
        w_bar.low_price = i_low_price;
        w_bar.close_price = i_close_price;
        w_bar.volume = i_volume;
        w_bar.trades = i_trades;
        w_bar.source_tag = i_source_tag;
        w_bar.bar_state = i_bar_state;
        w_bar.revision = i_revision;
        w_bar.last_in = i_last_in;
    end

    ohlc_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_bar(w_bar),
        .i_range_start(r_range_start), .i_range_end(r_range_end),
        .i_plot_width(r_plot_width), .o_push(w_push), .o_cls(w_qin), .i_full(w_full)
    );

    ohlc_queue u_queue (
        .i_clk, .i_rst_n, .i_push(w_push), .i_data(w_qin), .o_full(w_full),
        .i_pop(w_pop), .o_empty(w_empty), .o_data(w_qout)
    );

    ohlc_back u_back (
        .i_clk, .i_rst_n, .i_empty(w_empty), .i_cls(w_qout), .o_pop(w_pop),
        .o_valid, .i_stall, .o_res(w_res)
    );

    always_comb begin
        o_out_time = w_res.out_time;
        o_out_open = w_res.out_open;
        o_out_high = w_res.out_high;
        o_out_low = w_res.out_low;
        o_out_close = w_res.out_close;
        o_out_volume = w_res.out_volume;
        o_out_trades = w_res.out_trades;
        o_out_source = w_res.out_source;
        o_out_state = w_res.out_state;
        o_out_revision = w_res.out_revision;
        o_vwap_kept = w_res.vwap_kept;
        o_last_out = w_res.last_out;
    end

endmodule
`default_nettype wire
